// ----- hdl/cq_pkg.sv -----
// Shared types and codes for the collapsing handle queue.
// Used by cq_cell and collapsing_queue_with_purge_top; depends on nothing.
package cq_pkg;

  // Operation codes carried in the low bits of the input request.
  typedef enum logic [1:0] {
    KIND_ENQ   = 2'd0,
    KIND_DEQ   = 2'd1,
    KIND_PURGE = 2'd2
  } kind_e;

  // Result status codes.
  typedef enum logic [1:0] {
    STAT_DONE     = 2'd0,
    STAT_REFUSED  = 2'd1,
    STAT_NOTFOUND = 2'd2
  } status_e;

  // Controller states.
  typedef enum logic [0:0] {
    ST_IDLE  = 1'b0,
    ST_PURGE = 1'b1
  } state_e;

  // Field widths of the stream payloads.
  localparam int unsigned KindW  = 2;
  localparam int unsigned FieldW = 16;
  localparam int unsigned StatW  = 2;
  localparam int unsigned CountW = 5;

  // Broadcast control from the controller to every cell.
  typedef struct packed {
    logic shift;  // every cell takes its neighbor's entry (dequeue)
    logic load;   // the tail cell takes the key (enqueue)
  } cell_ctrl_t;

  // Purge wave handed from one cell to the next.
  typedef struct packed {
    logic wave;   // the purge front is at this cell in this cycle
    logic found;  // a matching entry was seen at or ahead of the front
  } chain_t;

endpackage

// ----- hdl/cq_cell.sv -----
// One slot of the collapsing queue: holds a handle and passes the purge wave on.
// Depends on cq_pkg for the control and chain structs.
module cq_cell #(
  parameter int unsigned HANDLE_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cq_pkg::cell_ctrl_t     ctrl_i,
  input  logic                   tail_sel_i,
  input  logic [HANDLE_BITS-1:0] key_i,
  input  logic [HANDLE_BITS-1:0] next_i,
  input  cq_pkg::chain_t         chain_i,
  output logic [HANDLE_BITS-1:0] slot_o,
  output cq_pkg::chain_t         chain_o
);
  import cq_pkg::*;

  logic [HANDLE_BITS-1:0] slot_d, slot_q;
  chain_t                 chain_d, chain_q;
  logic                   match;

  // Empty slots hold zero and the key is never zero during a purge.
  assign match = (slot_q == key_i);

  // Slot update: shift on dequeue, load at the tail, collapse at and behind a purge hit.
  always_comb begin
    slot_d = slot_q;
    if (ctrl_i.shift) begin
      slot_d = next_i;
    end else if (ctrl_i.load && tail_sel_i) begin
      slot_d = key_i;
    end else if (chain_i.wave && (chain_i.found || match)) begin
      slot_d = next_i;
    end
  end

  // The wave advances one cell per cycle and carries the hit flag along.
  always_comb begin
    chain_d.wave  = chain_i.wave;
    chain_d.found = chain_i.wave && (chain_i.found || match);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q  <= '0;
      chain_q <= '0;
    end else begin
      slot_q  <= slot_d;
      chain_q <= chain_d;
    end
  end

  assign slot_o  = slot_q;
  assign chain_o = chain_q;

endmodule

// ----- hdl/collapsing_queue_with_purge_top.sv -----
// Collapsing queue of process handles with enqueue, dequeue and purge by value.
// Depends on cq_pkg and cq_cell.
//
// The queue holds up to DEPTH nonzero handles in arrival order, one per cell.
// Enqueue, dequeue, a request with an unknown kind code, a purge of handle zero
// and a purge on an empty queue go from the input request straight to the result
// register. A purge of a real handle sends a wave down the row of cells, one
// cell per clock, and its result is loaded into the result register when the
// wave leaves the last cell. One request is in work at a time: a new request
// is taken when the block is idle and the result register is empty or being
// read in the same cycle. Each request yields one result.
module collapsing_queue_with_purge_top #(
  parameter int unsigned DEPTH       = 16,
  parameter int unsigned HANDLE_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Request: [1:0] kind, [17:2] item_handle, [23:18] zero.
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,
  // Result: [1:0] status, [17:2] out_handle, [22:18] entry_count, [23] is_empty.
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o
);
  import cq_pkg::*;

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  // Request fields.
  logic [KindW-1:0]       in_kind;
  logic [FieldW-1:0]      in_handle;
  logic [HANDLE_BITS-1:0] in_key;
  logic                   in_accept;

  assign in_kind   = s_axis_tdata_i[KindW-1:0];
  assign in_handle = s_axis_tdata_i[KindW+FieldW-1:KindW];
  assign in_key    = HANDLE_BITS'(in_handle);

  // Control state.
  state_e                 state_d, state_q;
  logic [CntW-1:0]        cnt_d, cnt_q;
  logic [HANDLE_BITS-1:0] key_q;
  logic                   start_d, start_q;

  // Result register.
  logic                   out_valid_d, out_valid_q;
  logic [StatW-1:0]       out_status_q;
  logic [FieldW-1:0]      out_handle_q;
  logic [CntW-1:0]        out_cnt_q;

  // Controller outputs.
  cell_ctrl_t             ctrl;
  logic                   res_load;
  status_e                res_status;
  logic [HANDLE_BITS-1:0] res_handle;
  logic [HANDLE_BITS-1:0] cell_key;

  // Cell row.
  logic [HANDLE_BITS-1:0] slot_w [DEPTH];
  logic [HANDLE_BITS-1:0] next_w [DEPTH];
  chain_t                 chain_in_w [DEPTH];
  chain_t                 chain_out_w [DEPTH];
  logic [DEPTH-1:0]       tail_sel;
  chain_t                 wave_head;
  chain_t                 wave_tail;

  assign s_axis_tready_o = (state_q == ST_IDLE) && (!out_valid_q || m_axis_tready_i);
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;

  // The purge wave enters the first cell in the cycle after the request is taken.
  assign wave_head.wave  = start_q;
  assign wave_head.found = 1'b0;
  assign wave_tail       = chain_out_w[DEPTH-1];

  // Compare against the stored key during a purge, else the incoming handle.
  assign cell_key = (state_q == ST_PURGE) ? key_q : in_key;

  // Row of cells, each fed by its neighbor toward the tail.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign tail_sel[i] = (cnt_q == CntW'(i));
    if (i == DEPTH - 1) begin : g_last
      assign next_w[i] = '0;
    end else begin : g_mid
      assign next_w[i] = slot_w[i+1];
    end
    if (i == 0) begin : g_first
      assign chain_in_w[i] = wave_head;
    end else begin : g_link
      assign chain_in_w[i] = chain_out_w[i-1];
    end

    cq_cell #(
      .HANDLE_BITS(HANDLE_BITS)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .tail_sel_i (tail_sel[i]),
      .key_i      (cell_key),
      .next_i     (next_w[i]),
      .chain_i    (chain_in_w[i]),
      .slot_o     (slot_w[i]),
      .chain_o    (chain_out_w[i])
    );
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept && (in_kind == KIND_PURGE) && (in_key != '0) && (cnt_q != '0)) begin
          state_d = ST_PURGE;
        end
      end
      ST_PURGE: begin
        if (wave_tail.wave) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Controller outputs: cell control, count update and the result.
  always_comb begin
    ctrl       = '0;
    start_d    = 1'b0;
    res_load   = 1'b0;
    res_status = STAT_REFUSED;
    res_handle = '0;
    cnt_d      = cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          res_load = 1'b1;
          case (in_kind)
            KIND_ENQ: begin
              if ((in_key != '0) && (cnt_q < CntW'(DEPTH))) begin
                ctrl.load  = 1'b1;
                cnt_d      = cnt_q + CntW'(1);
                res_status = STAT_DONE;
              end
            end
            KIND_DEQ: begin
              if (cnt_q == '0) begin
                res_status = STAT_NOTFOUND;
              end else begin
                ctrl.shift = 1'b1;
                cnt_d      = cnt_q - CntW'(1);
                res_status = STAT_DONE;
                res_handle = slot_w[0];
              end
            end
            KIND_PURGE: begin
              if ((in_key == '0) || (cnt_q == '0)) begin
                res_status = STAT_NOTFOUND;
              end else begin
                res_load = 1'b0;
                start_d  = 1'b1;
              end
            end
            default: res_status = STAT_REFUSED;
          endcase
        end
      end
      ST_PURGE: begin
        if (wave_tail.wave) begin
          res_load = 1'b1;
          if (wave_tail.found) begin
            res_status = STAT_DONE;
            res_handle = key_q;
            cnt_d      = cnt_q - CntW'(1);
          end else begin
            res_status = STAT_NOTFOUND;
          end
        end
      end
      default: res_load = 1'b0;
    endcase
  end

  // Result register holds until the consumer takes it.
  always_comb begin
    out_valid_d = out_valid_q && !m_axis_tready_i;
    if (res_load) begin
      out_valid_d = 1'b1;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      start_q     <= start_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      key_q <= in_key;
    end
    if (res_load) begin
      out_status_q <= res_status;
      out_handle_q <= FieldW'(res_handle);
      out_cnt_q    <= cnt_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {(out_cnt_q == '0), CountW'(out_cnt_q), out_handle_q, out_status_q};

endmodule

// ----- tb/collapsing_queue_with_purge_top_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for collapsing_queue_with_purge_top.
// Depends on cq_pkg and the RTL of the block; reads and writes no files.
module collapsing_queue_with_purge_top_tb;
  import cq_pkg::*;

  localparam int unsigned Depth     = 16;
  localparam int unsigned NumRandom = 1550;
  localparam int unsigned Limit     = 400000;
  localparam int unsigned HoldLen   = 300;
  localparam int unsigned MaxShown  = 10;
  // The fourth kind code has no operation behind it; the block refuses it.
  localparam logic [1:0]  KindUnused = 2'd3;

  // One result as the block reports it.
  typedef struct packed {
    status_e     status;
    logic [15:0] handle;
    logic [4:0]  count;
    logic        empty;
  } result_t;

  // One request waiting to be offered, with the idle cycles in front of it.
  typedef struct {
    logic [1:0]  kind;
    logic [15:0] handle;
    int          gap;
    bit          drain;
  } req_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  // Request: [1:0] kind, [17:2] item_handle, [23:18] zero.
  logic [23:0] s_axis_tdata_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  // Result: [1:0] status, [17:2] out_handle, [22:18] entry_count, [23] is_empty.
  logic [23:0] m_axis_tdata_o;

  req_t        req_fifo[$];
  result_t     pending_results[$];
  logic [15:0] held_now[$];
  logic [15:0] gen_held[$];

  int unsigned n_offered = 0;
  int unsigned n_taken = 0;
  int unsigned n_results = 0;
  int unsigned n_fail = 0;
  int unsigned cycles = 0;
  int unsigned kind_seen[4];
  int unsigned purge_hits = 0;
  int unsigned peak_fill = 0;

  collapsing_queue_with_purge_top #(
    .DEPTH      (Depth),
    .HANDLE_BITS(16)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  // Applies one request to a queue of handles and returns the result it gives.
  function automatic result_t queue_step(ref logic [15:0] held[$],
                                         input logic [1:0] kind,
                                         input logic [15:0] h);
    result_t r;
    r.status = STAT_REFUSED;
    r.handle = '0;
    if (kind == KIND_ENQ) begin
      if (h != 0 && held.size() < Depth) begin
        held.push_back(h);
        r.status = STAT_DONE;
      end
    end else if (kind == KIND_DEQ) begin
      if (held.size() == 0) begin
        r.status = STAT_NOTFOUND;
      end else begin
        r.handle = held.pop_front();
        r.status = STAT_DONE;
      end
    end else if (kind == KIND_PURGE) begin
      r.status = STAT_NOTFOUND;
      if (h != 0) begin
        // Only the copy nearest the head goes.
        for (int i = 0; i < held.size(); i++) begin
          if (held[i] == h) begin
            held.delete(i);
            r.handle = h;
            r.status = STAT_DONE;
            break;
          end
        end
      end
    end
    r.count = 5'(held.size());
    r.empty = (held.size() == 0);
    return r;
  endfunction

  // Queues a request and tracks what the queue will hold once it is served.
  task automatic add_req(input logic [1:0] kind, input logic [15:0] h,
                         input int gap, input bit drain);
    req_t r;
    result_t ignored;
    r.kind = kind;
    r.handle = h;
    r.gap = gap;
    r.drain = drain;
    req_fifo.push_back(r);
    ignored = queue_step(gen_held, kind, h);
  endtask

  // Handle with a bias toward a small pool, so that duplicates and hits occur.
  function automatic logic [15:0] pick_handle();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 5) return 16'h0000;
    if (roll < 75) return 16'($urandom_range(1, 24));
    if (roll < 90) return 16'($urandom);
    return (roll < 95) ? 16'hFFFF : 16'h8000;
  endfunction

  task automatic note_mismatch(input string what, input result_t want, input result_t got);
    string exp_s;
    n_fail++;
    if (n_fail <= MaxShown) begin
      exp_s = $sformatf("expected status %0d handle %h count %0d empty %0b",
                        want.status, want.handle, want.count, want.empty);
      $display("%0t: %s: %s, got status %0d handle %h count %0d empty %0b",
               $realtime, what, exp_s, got.status, got.handle, got.count, got.empty);
    end
  endtask

  // Clock.
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Request driver: offers the next queued request after its gap, holding it until taken.
  req_t nxt;
  bit   have_nxt = 0;
  int   gap_left = 0;
  always @(negedge clk_i) begin
    if (rst_ni && !(s_axis_tvalid_i && n_taken != n_offered)) begin
      if (!have_nxt && req_fifo.size() != 0) begin
        nxt = req_fifo.pop_front();
        have_nxt = 1;
        gap_left = nxt.gap;
      end
      if (!have_nxt || gap_left != 0 || (nxt.drain && pending_results.size() != 0)) begin
        s_axis_tvalid_i <= 1'b0;
        if (gap_left != 0) gap_left--;
      end else begin
        s_axis_tvalid_i <= 1'b1;
        s_axis_tdata_i <= {6'd0, nxt.handle, nxt.kind};
        n_offered++;
        have_nxt = 0;
      end
    end
  end

  // Result receiver: a random stall after each result, calm stretches, and two long hold-offs.
  int unsigned rx_seen = 0;
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  int unsigned hold_idx = 0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready_i <= 1'b0;
      end else if (hold_idx < 2 && n_taken >= ((hold_idx == 0) ? 400 : 1100)) begin
        hold_left = HoldLen;
        hold_idx++;
        m_axis_tready_i <= 1'b0;
      end else begin
        if (n_results != rx_seen) begin
          rx_seen = n_results;
          stall_left = ((n_results / 128) % 4 == 1) ? 0 : $urandom_range(0, 13);
        end
        if (stall_left != 0) begin
          stall_left--;
          m_axis_tready_i <= 1'b0;
        end else begin
          m_axis_tready_i <= 1'b1;
        end
      end
    end
  end

  // Monitor: checks each result against the oldest expectation, then predicts taken requests.
  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    logic [1:0] kind;
    cycles++;
    if (cycles > Limit) begin
      $display("Timeout after %0d cycles with %0d results outstanding.",
               cycles, pending_results.size());
      $display("collapsing_queue_with_purge_top: mismatch");
      $finish;
    end else if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        n_results++;
        got.status = status_e'(m_axis_tdata_o[1:0]);
        got.handle = m_axis_tdata_o[17:2];
        got.count = m_axis_tdata_o[22:18];
        got.empty = m_axis_tdata_o[23];
        if (pending_results.size() == 0) begin
          note_mismatch("result with no request behind it", '0, got);
        end else begin
          want = pending_results.pop_front();
          if (got.status != want.status || got.handle != want.handle ||
              got.count != want.count || got.empty != want.empty)
            note_mismatch($sformatf("result %0d", n_results - 1), want, got);
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        kind = s_axis_tdata_i[1:0];
        want = queue_step(held_now, kind, s_axis_tdata_i[17:2]);
        pending_results.push_back(want);
        n_taken++;
        kind_seen[kind]++;
        if (kind == KIND_PURGE && want.status == STAT_DONE) purge_hits++;
        if (held_now.size() > peak_fill) peak_fill = held_now.size();
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    int unsigned phase;
    int unsigned roll;
    int gap;
    logic [1:0] kind;
    logic [15:0] h;

    // Directed part: empty-queue cases, handle none, unused kind, duplicates, full queue.
    add_req(KIND_DEQ, 16'h0000, 0, 0);
    add_req(KIND_PURGE, 16'h0007, 0, 0);
    add_req(KIND_ENQ, 16'h0000, 3, 0);
    add_req(KindUnused, 16'hFFFF, 0, 0);
    add_req(KIND_ENQ, 16'hFFFF, 1, 0);
    add_req(KIND_ENQ, 16'h0005, 0, 0);
    add_req(KIND_ENQ, 16'h8000, 0, 0);
    add_req(KIND_ENQ, 16'h0005, 2, 0);
    add_req(KIND_PURGE, 16'h0000, 0, 0);
    add_req(KIND_PURGE, 16'h1234, 0, 0);
    add_req(KIND_PURGE, 16'h0005, 0, 0);
    add_req(KIND_DEQ, 16'hFFFF, 5, 0);
    for (int i = 0; i < 14; i++) add_req(KIND_ENQ, 16'(16'h0100 + i), 0, 0);
    add_req(KIND_ENQ, 16'h0009, 0, 0);
    add_req(KIND_PURGE, 16'h010D, 0, 0);
    add_req(KIND_PURGE, 16'h8000, 0, 0);
    add_req(KIND_DEQ, 16'h0000, 0, 0);

    // Random part: phases that fill, drain, balance and purge, mostly against held handles.
    for (int n = 0; n < NumRandom; n++) begin
      phase = (n / 100) % 4;
      roll = $urandom_range(0, 99);
      if (roll < 5) begin
        kind = KindUnused;
      end else if (roll < ((phase == 0) ? 65 : (phase == 1) ? 30 : (phase == 2) ? 45 : 50)) begin
        kind = KIND_ENQ;
      end else if (roll < ((phase == 0) ? 80 : (phase == 1) ? 75 : (phase == 2) ? 70 : 60)) begin
        kind = KIND_DEQ;
      end else begin
        kind = KIND_PURGE;
      end
      if (kind == KIND_PURGE && gen_held.size() != 0 && $urandom_range(0, 99) < 60)
        h = gen_held[$urandom_range(0, gen_held.size() - 1)];
      else if (kind == KIND_ENQ || kind == KIND_PURGE)
        h = pick_handle();
      else
        h = 16'($urandom);
      gap = ((n / 150) % 5 == 2) ? 0 : $urandom_range(0, 13);
      add_req(kind, h, gap, (n == 0 || n == 700));
    end

    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (req_fifo.size() != 0 || have_nxt || n_taken != n_offered ||
           pending_results.size() != 0)
      @(posedge clk_i);
    // Leave time for a last purge walk and room for any stray result.
    repeat (3 * Depth) @(posedge clk_i);

    $display("Ran %0d enqueues, %0d dequeues, %0d purges (%0d hits), %0d unused-kind requests.",
             kind_seen[KIND_ENQ], kind_seen[KIND_DEQ], kind_seen[KIND_PURGE], purge_hits,
             kind_seen[KindUnused]);
    $display("Peak occupancy %0d of %0d; %0d results checked, %0d failures.",
             peak_fill, Depth, n_results, n_fail);
    if (n_fail == 0) begin
      $display("collapsing_queue_with_purge_top: match");
    end else begin
      $display("collapsing_queue_with_purge_top: mismatch");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/cq_pkg.sv
hdl/cq_cell.sv
hdl/collapsing_queue_with_purge_top.sv
tb/collapsing_queue_with_purge_top_tb.sv
